[hw/rtl/mbvh_pkg.sv]
// Shared types and constants for the mode-by-value histogram block.
`timescale 1ns / 1ps

package mbvh_pkg;

  // Fixed port widths
  localparam int IN_VALUE_W     = 16;
  localparam int OUT_CNT_W      = 7;

  // Parameter defaults
  localparam int MAX_ITEMS_DEF  = 64;
  localparam int VALUE_BITS_DEF = 16;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } mbvh_state_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;   // insert or count the incoming value
    logic shf;   // every cell takes its upper neighbor's contents
    logic wrap;  // top cell takes cell 0 (rotate) instead of an empty entry
    logic clr;   // drop all entries
  } cell_ctl_t;

endpackage

[hw/rtl/mbvh_cell.sv]
// One cell of the sorted value/count chain.
`timescale 1ns / 1ps

module mbvh_cell #(
  parameter int VALUE_BITS = mbvh_pkg::VALUE_BITS_DEF,
  parameter int CNT_W      = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mbvh_pkg::cell_ctl_t          ctl,
  input  logic signed [VALUE_BITS-1:0] din,
  input  logic                         hit_any,
  input  logic                         prev_lt,
  input  logic signed [VALUE_BITS-1:0] prev_value,
  input  logic        [CNT_W-1:0]      prev_count,
  input  logic                         prev_used,
  input  logic signed [VALUE_BITS-1:0] next_value,
  input  logic        [CNT_W-1:0]      next_count,
  input  logic                         next_used,
  output logic                         lt,
  output logic                         eq,
  output logic signed [VALUE_BITS-1:0] value,
  output logic        [CNT_W-1:0]      count,
  output logic                         used
);

  logic signed [VALUE_BITS-1:0] value_r, value_nxt;
  logic        [CNT_W-1:0]      count_r, count_nxt;
  logic                         used_r, used_nxt;

  // Compare against the incoming value
  assign lt = used_r && (value_r < din);
  assign eq = used_r && (value_r == din);

  // Next contents: clear, shift down, or insert/count
  always_comb begin
    value_nxt = value_r;
    count_nxt = count_r;
    used_nxt  = used_r;
    if (ctl.clr) begin
      count_nxt = '0;
      used_nxt  = 1'b0;
    end else if (ctl.shf) begin
      value_nxt = next_value;
      count_nxt = next_count;
      used_nxt  = next_used;
    end else if (ctl.ins) begin
      if (hit_any) begin
        if (eq) begin
          count_nxt = count_r + 1'b1;
        end
      end else if (!lt) begin
        if (prev_lt) begin
          // insertion point
          value_nxt = din;
          count_nxt = CNT_W'(1);
          used_nxt  = 1'b1;
        end else begin
          // make room: move up by one
          value_nxt = prev_value;
          count_nxt = prev_count;
          used_nxt  = prev_used;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      used_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      used_r  <= used_nxt;
    end
  end

  // value has no reset: read only where used is set
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign count = count_r;
  assign used  = used_r;

endmodule

[hw/rtl/mbvh_head.sv]
// Sequencer at the chain head: item intake, max search, mode emission.
`timescale 1ns / 1ps

module mbvh_head #(
  parameter int MAX_ITEMS  = mbvh_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = mbvh_pkg::VALUE_BITS_DEF,
  parameter int CNT_W      = 7
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic                                   in_last,
  output logic                                   busy,
  output mbvh_pkg::cell_ctl_t                    ctl,
  input  logic signed [VALUE_BITS-1:0]           head_value,
  input  logic        [CNT_W-1:0]                head_count,
  input  logic                                   head_used,
  output logic                                   out_valid,
  output logic signed [mbvh_pkg::IN_VALUE_W-1:0] out_mode_value,
  output logic        [mbvh_pkg::OUT_CNT_W-1:0]  out_mode_count,
  output logic        [mbvh_pkg::OUT_CNT_W-1:0]  out_max_freq,
  output logic                                   out_overflow,
  output logic                                   out_final_res
);

  localparam int STEP_W = $clog2(MAX_ITEMS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_ITEMS - 1);
  localparam logic [CNT_W-1:0]  CAP       = CNT_W'(MAX_ITEMS);

  mbvh_pkg::mbvh_state_t st_r, st_nxt;
  logic [CNT_W-1:0]  items_r, items_nxt;
  logic              drop_r, drop_nxt;
  logic [CNT_W-1:0]  max_r, max_nxt;
  logic [CNT_W-1:0]  modes_r, modes_nxt;
  logic [CNT_W-1:0]  emit_r, emit_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  emit_inc;
  logic              hit;

  logic                                   ov_r, ov_nxt;
  logic                                   fin_r, fin_nxt;
  logic signed [mbvh_pkg::IN_VALUE_W-1:0] mv_r;
  logic        [mbvh_pkg::OUT_CNT_W-1:0]  mc_r, mf_r;
  logic                                   of_r;

  assign busy     = (st_r != mbvh_pkg::ST_LOAD);
  assign emit_inc = emit_r + 1'b1;
  assign hit      = head_used && (head_count == max_r);

  // Next state and cell commands
  always_comb begin
    st_nxt    = st_r;
    ctl       = '0;
    items_nxt = items_r;
    drop_nxt  = drop_r;
    max_nxt   = max_r;
    modes_nxt = modes_r;
    emit_nxt  = emit_r;
    step_nxt  = step_r;
    ov_nxt    = 1'b0;
    fin_nxt   = 1'b0;
    case (st_r)
      mbvh_pkg::ST_LOAD: begin
        if (start) begin
          if (items_r < CAP) begin
            ctl.ins   = 1'b1;
            items_nxt = items_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            st_nxt    = mbvh_pkg::ST_SCAN;
            max_nxt   = '0;
            modes_nxt = '0;
            emit_nxt  = '0;
            step_nxt  = '0;
          end
        end
      end
      mbvh_pkg::ST_SCAN: begin
        // one full rotation: running max and its multiplicity
        ctl.shf  = 1'b1;
        ctl.wrap = 1'b1;
        if (head_used) begin
          if (head_count > max_r) begin
            max_nxt   = head_count;
            modes_nxt = CNT_W'(1);
          end else if (head_count == max_r) begin
            modes_nxt = modes_r + 1'b1;
          end
        end
        if (step_r == STEP_LAST) begin
          st_nxt = mbvh_pkg::ST_EMIT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      mbvh_pkg::ST_EMIT: begin
        // shift out in ascending order, emit cells at the max
        ctl.shf = 1'b1;
        if (hit) begin
          ov_nxt   = 1'b1;
          emit_nxt = emit_inc;
          if (emit_inc == modes_r) begin
            fin_nxt   = 1'b1;
            ctl.clr   = 1'b1;
            st_nxt    = mbvh_pkg::ST_LOAD;
            items_nxt = '0;
            drop_nxt  = 1'b0;
          end
        end
      end
      default: begin
        st_nxt = mbvh_pkg::ST_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= mbvh_pkg::ST_LOAD;
      items_r <= '0;
      drop_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      items_r <= items_nxt;
      drop_r  <= drop_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Scan bookkeeping and result payload
  always_ff @(posedge clk) begin
    max_r   <= max_nxt;
    modes_r <= modes_nxt;
    emit_r  <= emit_nxt;
    step_r  <= step_nxt;
    fin_r   <= fin_nxt;
    if (ov_nxt) begin
      mv_r <= mbvh_pkg::IN_VALUE_W'(head_value);
      mc_r <= mbvh_pkg::OUT_CNT_W'(modes_r);
      mf_r <= mbvh_pkg::OUT_CNT_W'(max_r);
      of_r <= drop_r;
    end
  end

  assign out_valid      = ov_r;
  assign out_mode_value = mv_r;
  assign out_mode_count = mc_r;
  assign out_max_freq   = mf_r;
  assign out_overflow   = of_r;
  assign out_final_res  = ov_r && fin_r;

`ifndef SYNTH
  // a result only follows an emission cycle
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(st_r == mbvh_pkg::ST_EMIT))
    else $error("result strobe outside emission");

  // the final result of a run returns the block to loading
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_res) |-> (st_r == mbvh_pkg::ST_LOAD))
    else $error("final result while still busy");

  // the set is never larger than the table
  a_items_cap: assert property (@(posedge clk) disable iff (!rst_n)
    items_r <= CAP)
    else $error("item count beyond capacity");

  // emission always has a nonempty mode set
  a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == mbvh_pkg::ST_EMIT) |-> (max_r != '0 && modes_r != '0))
    else $error("emission with empty mode set");
`endif

endmodule

[hw/rtl/mode_by_value_histogram_top.sv]
// Top level: sorted cell chain with the sequencer at its head.
// Intake: one transaction per cycle while busy is low, sorted into the chain in that cycle.
// After the last item: the chain rotates once to find the max count, then shifts toward the
//   head; each matching cell gives a result the cycle after it is at the head.
// busy is high from the cycle after the last item until the final result appears.
// Reset (synchronous, rst_n low): table empty, item count, overflow flag and strobe cleared; no output stall.
`timescale 1ns / 1ps

module mode_by_value_histogram_top #(
  parameter int MAX_ITEMS  = mbvh_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = mbvh_pkg::VALUE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [mbvh_pkg::IN_VALUE_W-1:0] in_value,
  input  logic                                   in_last,
  output logic                                   out_valid,
  output logic signed [mbvh_pkg::IN_VALUE_W-1:0] out_mode_value,
  output logic        [mbvh_pkg::OUT_CNT_W-1:0]  out_mode_count,
  output logic        [mbvh_pkg::OUT_CNT_W-1:0]  out_max_freq,
  output logic                                   out_overflow,
  output logic                                   out_final_res
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  mbvh_pkg::cell_ctl_t          ctl;
  logic signed [VALUE_BITS-1:0] din;
  logic signed [VALUE_BITS-1:0] val_a [MAX_ITEMS];
  logic        [CNT_W-1:0]      cnt_a [MAX_ITEMS];
  logic        [MAX_ITEMS-1:0]  used_a, lt_a, eq_a;
  logic signed [VALUE_BITS-1:0] tail_value;
  logic        [CNT_W-1:0]      tail_count;
  logic                         tail_used;
  logic                         hit_any;

  // wrap or sign-extend the input to the stored width
  assign din     = VALUE_BITS'(in_value);
  assign hit_any = |eq_a;

  // top cell refills from cell 0 while rotating, else with an empty entry
  assign tail_value = ctl.wrap ? val_a[0] : '0;
  assign tail_count = ctl.wrap ? cnt_a[0] : '0;
  assign tail_used  = ctl.wrap ? used_a[0] : 1'b0;

  // Cell chain
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                         p_lt, n_used;
    logic signed [VALUE_BITS-1:0] p_val, n_val;
    logic        [CNT_W-1:0]      p_cnt, n_cnt;
    logic                         p_used;

    if (i == 0) begin : g_first
      assign p_lt   = 1'b1;
      assign p_val  = '0;
      assign p_cnt  = '0;
      assign p_used = 1'b0;
    end else begin : g_mid
      assign p_lt   = lt_a[i-1];
      assign p_val  = val_a[i-1];
      assign p_cnt  = cnt_a[i-1];
      assign p_used = used_a[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_last
      assign n_val  = tail_value;
      assign n_cnt  = tail_count;
      assign n_used = tail_used;
    end else begin : g_inner
      assign n_val  = val_a[i+1];
      assign n_cnt  = cnt_a[i+1];
      assign n_used = used_a[i+1];
    end

    mbvh_cell #(
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .din        (din),
      .hit_any    (hit_any),
      .prev_lt    (p_lt),
      .prev_value (p_val),
      .prev_count (p_cnt),
      .prev_used  (p_used),
      .next_value (n_val),
      .next_count (n_cnt),
      .next_used  (n_used),
      .lt         (lt_a[i]),
      .eq         (eq_a[i]),
      .value      (val_a[i]),
      .count      (cnt_a[i]),
      .used       (used_a[i])
    );
  end

  // Sequencer
  mbvh_head #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS),
    .CNT_W      (CNT_W)
  ) u_head (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_last        (in_last),
    .busy           (busy),
    .ctl            (ctl),
    .head_value     (val_a[0]),
    .head_count     (cnt_a[0]),
    .head_used      (used_a[0]),
    .out_valid      (out_valid),
    .out_mode_value (out_mode_value),
    .out_mode_count (out_mode_count),
    .out_max_freq   (out_max_freq),
    .out_overflow   (out_overflow),
    .out_final_res  (out_final_res)
  );

endmodule
